// File: sv/light_off_delay_fade_controller_top_assert.svh
// Assertion macros for the light controller checker.
`ifndef LIGHT_OFF_DELAY_FADE_CONTROLLER_TOP_ASSERT_SVH
`define LIGHT_OFF_DELAY_FADE_CONTROLLER_TOP_ASSERT_SVH

// Same-cycle implication, masked during reset.
`define LOFC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, masked during reset.
`define LOFC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

// Next-cycle implication that also holds through reset.
`define LOFC_ASSERT_RST(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

// File: sv/lofc_pkg.sv
// Types, register indexes and helpers for the light off-delay fade controller.
`default_nettype none
package lofc_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 8;

  localparam logic [CFG_IDX_W-1:0] REG_DELAY_MINUTES       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DELAY_SECONDS       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TICKS_PER_SECOND    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FADE_INTERVAL_TICKS = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FADE_STEP           = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_INTENSITY       = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_INTENSITY       = 3'd6;

  localparam logic [7:0] DEF_DELAY_MINUTES       = 8'd15;
  localparam logic [5:0] DEF_DELAY_SECONDS       = 6'd0;
  localparam logic [7:0] DEF_TICKS_PER_SECOND    = 8'd250;
  localparam logic [7:0] DEF_FADE_INTERVAL_TICKS = 8'd5;
  localparam logic [7:0] DEF_FADE_STEP           = 8'd4;
  localparam logic [7:0] DEF_MAX_INTENSITY       = 8'd200;
  localparam logic [7:0] DEF_MIN_INTENSITY       = 8'd0;

  localparam int QUEUE_DEPTH = 2;

  typedef struct packed {
    logic [7:0] delay_minutes;
    logic [5:0] delay_seconds;
    logic [7:0] ticks_per_second;
    logic [7:0] fade_interval_ticks;
    logic [7:0] fade_step;
    logic [7:0] max_intensity;
    logic [7:0] min_intensity;
  } lofc_cfg_t;

  // classified pass handed from front to back
  typedef struct packed {
    logic tick;
    logic busy;
    logic door_closed;
  } lofc_item_t;

  typedef struct packed {
    logic       relay_on;
    logic [7:0] intensity;
    logic       door_closed;
  } lofc_result_t;

  // when min > max, values up to min give min and values above it give max
  function automatic logic [7:0] clamp_level(input logic [8:0] v,
                                             input logic [7:0] lo,
                                             input logic [7:0] hi);
    logic [7:0] r;
    if (v <= {1'b0, lo}) begin
      r = lo;
    end else if (v >= {1'b0, hi}) begin
      r = hi;
    end else begin
      r = v[7:0];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// File: sv/light_off_delay_fade_controller_top.sv
// Top level of the garage light off-delay controller with LED fade.
//
// Input channel (in_valid/in_ready): one word per polling pass carrying
// motion, door_raw (1 = closed) and tick (one timer tick since last pass).
// Output channel (out_valid/out_ready): exactly one word per input word,
// in order: relay_on, intensity (LED duty) and debounced door_closed.
// Config port: cfg_we writes cfg_data into register cfg_index at the edge.
// The user must write only while no word is in flight; the block does not
// enforce it. Unknown indexes are ignored. An accepted word goes through the
// queue and the output register; one word per clock while words are taken.
// The front part debounces and classifies words into a 2-entry queue; the
// back part pops one word a cycle into the output register whenever that
// register is empty or being taken.
// Receiver stall: the output word holds; the queue fills behind it and
// in_ready drops once both queue entries are occupied.
// Reset (rst, synchronous): config returns to defaults, counters and
// level clear, relay off, previous door sample reads closed, channels empty.
`default_nettype none
module light_off_delay_fade_controller_top #(
  parameter int SECONDS_PER_MINUTE = 60
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           motion,
  input  logic                           door_raw,
  input  logic                           tick,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic                           relay_on,
  output logic [7:0]                     intensity,
  output logic                           door_closed,
  input  logic                           cfg_we,
  input  logic [lofc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [lofc_pkg::CFG_DATA_W-1:0] cfg_data
);
  import lofc_pkg::*;

  lofc_cfg_t    cfg;
  lofc_item_t   front_item;
  lofc_item_t   back_item;
  lofc_result_t result;
  logic         push;
  logic         pop;
  logic         q_space;
  logic         q_valid;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.delay_minutes       <= DEF_DELAY_MINUTES;
      cfg.delay_seconds       <= DEF_DELAY_SECONDS;
      cfg.ticks_per_second    <= DEF_TICKS_PER_SECOND;
      cfg.fade_interval_ticks <= DEF_FADE_INTERVAL_TICKS;
      cfg.fade_step           <= DEF_FADE_STEP;
      cfg.max_intensity       <= DEF_MAX_INTENSITY;
      cfg.min_intensity       <= DEF_MIN_INTENSITY;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_DELAY_MINUTES:       cfg.delay_minutes       <= cfg_data;
        REG_DELAY_SECONDS:       cfg.delay_seconds       <= cfg_data[5:0];
        REG_TICKS_PER_SECOND:    cfg.ticks_per_second    <= cfg_data;
        REG_FADE_INTERVAL_TICKS: cfg.fade_interval_ticks <= cfg_data;
        REG_FADE_STEP:           cfg.fade_step           <= cfg_data;
        REG_MAX_INTENSITY:       cfg.max_intensity       <= cfg_data;
        REG_MIN_INTENSITY:       cfg.min_intensity       <= cfg_data;
        default:                 cfg                     <= cfg;
      endcase
    end
  end

  lofc_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .motion   (motion),
    .door_raw (door_raw),
    .tick     (tick),
    .q_space  (q_space),
    .push     (push),
    .item     (front_item)
  );

  lofc_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (front_item),
    .has_space (q_space),
    .pop       (pop),
    .not_empty (q_valid),
    .pop_item  (back_item)
  );

  lofc_back #(
    .SECONDS_PER_MINUTE (SECONDS_PER_MINUTE)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .item_valid (q_valid),
    .item       (back_item),
    .item_pop   (pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .result     (result)
  );

  assign relay_on    = result.relay_on;
  assign intensity   = result.intensity;
  assign door_closed = result.door_closed;

endmodule
`default_nettype wire

// File: sv/lofc_queue.sv
// Two-entry queue between the front and back parts.
`default_nettype none
module lofc_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  lofc_pkg::lofc_item_t push_item,
  output logic               has_space,
  input  logic               pop,
  output logic               not_empty,
  output lofc_pkg::lofc_item_t pop_item
);
  import lofc_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  lofc_item_t         entries [QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   count;

  assign has_space = (count != CNT_W'(QUEUE_DEPTH));
  assign not_empty = (count != '0);
  assign pop_item  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + CNT_W'(1);
        2'b01:   count <= count - CNT_W'(1);
        default: count <= count;
      endcase
    end
  end

endmodule
`default_nettype wire

// File: sv/lofc_front.sv
// Front part: takes input words, debounces the door and classifies the pass.
`default_nettype none
module lofc_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               motion,
  input  logic               door_raw,
  input  logic               tick,
  input  logic               q_space,
  output logic               push,
  output lofc_pkg::lofc_item_t item
);
  import lofc_pkg::*;

  logic prev_door;
  logic closed;

  assign in_ready = q_space;
  assign push     = in_valid && q_space;

  // closed only on two high samples in a row
  assign closed           = door_raw & prev_door;
  assign item.door_closed = closed;
  assign item.busy        = motion | ~closed;
  assign item.tick        = tick;

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_door <= 1'b1;
    end else if (push) begin
      prev_door <= door_raw;
    end
  end

endmodule
`default_nettype wire

// File: sv/lofc_back.sv
// Back part: prescaler, expiry, fade ramp, relay and the output register.
`default_nettype none
module lofc_back #(
  parameter int SECONDS_PER_MINUTE = 60
) (
  input  logic                 clk,
  input  logic                 rst,
  input  lofc_pkg::lofc_cfg_t  cfg,
  input  logic                 item_valid,
  input  lofc_pkg::lofc_item_t item,
  output logic                 item_pop,
  output logic                 out_valid,
  input  logic                 out_ready,
  output lofc_pkg::lofc_result_t result
);
  import lofc_pkg::*;

  localparam int SEC_W = $clog2(SECONDS_PER_MINUTE + 1);
  localparam logic [SEC_W-1:0] SEC_WRAP = SEC_W'(SECONDS_PER_MINUTE);

  logic [7:0]       tick_count,   tick_count_next;
  logic [SEC_W-1:0] second_count, second_count_next;
  logic [7:0]       minute_count, minute_count_next;
  logic             expired,      expired_next;
  logic [7:0]       fade_count,   fade_count_next;
  logic [7:0]       level,        level_next;
  logic             relay_state,  relay_state_next;

  logic             fade_now;
  logic [7:0]       tc_inc;
  logic [7:0]       fc_inc;
  logic [SEC_W-1:0] sec_inc;

  assign item_pop = item_valid && (!out_valid || out_ready);

  always_comb begin
    tick_count_next   = tick_count;
    second_count_next = second_count;
    minute_count_next = minute_count;
    expired_next      = expired;
    fade_count_next   = fade_count;
    level_next        = level;
    relay_state_next  = relay_state;
    fade_now          = 1'b0;
    tc_inc            = tick_count + 8'd1;
    fc_inc            = fade_count + 8'd1;
    sec_inc           = '0;

    if (item.tick) begin
      tick_count_next = tc_inc;
      // expiry check comes before the prescaler advance
      if ((6'(second_count) >= cfg.delay_seconds) &&
          (minute_count >= cfg.delay_minutes)) begin
        second_count_next = SEC_W'(6'(second_count) - cfg.delay_seconds);
        minute_count_next = minute_count - cfg.delay_minutes;
        expired_next      = 1'b1;
      end
      if (tc_inc >= cfg.ticks_per_second) begin
        tick_count_next = tc_inc - cfg.ticks_per_second;
        sec_inc         = second_count_next + SEC_W'(1);
        if (sec_inc >= SEC_WRAP) begin
          second_count_next = sec_inc - SEC_WRAP;
          if (minute_count_next != 8'hFF) begin
            minute_count_next = minute_count_next + 8'd1;
          end
        end else begin
          second_count_next = sec_inc;
        end
      end
      fade_count_next = fc_inc;
      if (fc_inc >= cfg.fade_interval_ticks) begin
        fade_count_next = fc_inc - cfg.fade_interval_ticks;
        fade_now        = 1'b1;
      end
    end

    if (fade_now) begin
      if (item.busy) begin
        if (level < cfg.max_intensity) begin
          level_next = clamp_level({1'b0, level} + {1'b0, cfg.fade_step},
                                   cfg.min_intensity, cfg.max_intensity);
        end
      end else if (level > cfg.min_intensity) begin
        if (cfg.fade_step > level) begin
          level_next = cfg.min_intensity;
        end else begin
          level_next = clamp_level({1'b0, level - cfg.fade_step},
                                   cfg.min_intensity, cfg.max_intensity);
        end
      end
    end

    if (item.busy) begin
      relay_state_next  = 1'b1;
      second_count_next = '0;
      minute_count_next = '0;
    end else if (expired_next) begin
      relay_state_next = 1'b0;
      expired_next     = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_count   <= '0;
      second_count <= '0;
      minute_count <= '0;
      expired      <= 1'b0;
      fade_count   <= '0;
      level        <= '0;
      relay_state  <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      if (item_pop) begin
        tick_count   <= tick_count_next;
        second_count <= second_count_next;
        minute_count <= minute_count_next;
        expired      <= expired_next;
        fade_count   <= fade_count_next;
        level        <= level_next;
        relay_state  <= relay_state_next;
        out_valid    <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (item_pop) begin
      result.relay_on    <= relay_state_next;
      result.intensity   <= level_next;
      result.door_closed <= item.door_closed;
    end
  end

endmodule
`default_nettype wire

// File: sv/lofc_check.sv
// Port-level checker for the light controller top, with its bind.
`default_nettype none
`include "light_off_delay_fade_controller_top_assert.svh"
module lofc_check (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic       relay_on,
  input logic [7:0] intensity,
  input logic       door_closed
);

  // words accepted but not yet delivered
  logic [2:0] pending;
  logic       in_acc;
  logic       out_acc;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else begin
      case ({in_acc, out_acc})
        2'b10:   pending <= pending + 3'd1;
        2'b01:   pending <= pending - 3'd1;
        default: pending <= pending;
      endcase
    end
  end

  `LOFC_ASSERT_NXT(a_out_hold, out_valid && !out_ready,
    out_valid && $stable(intensity) && $stable(relay_on) && $stable(door_closed),
    "output word changed while stalled")
  `LOFC_ASSERT_IMP(a_open_door_relay, out_valid && !door_closed, relay_on,
    "relay off on a word with the door open")
  `LOFC_ASSERT_RST(a_reset_empty, rst, !out_valid,
    "output valid right after reset")
  `LOFC_ASSERT_IMP(a_no_extra_word, out_valid, pending != 3'd0,
    "output word without an accepted input word")
  `LOFC_ASSERT_IMP(a_pending_bound, 1'b1, pending <= 3'd3,
    "more words in flight than queue and output register hold")

endmodule

bind light_off_delay_fade_controller_top lofc_check u_check (.*);
`default_nettype wire
